[src/csma_pkg.sv]
package csma_pkg;

  localparam int RETRY_LIMIT     = 16;
  localparam int BACKOFF_CAP_EXP = 10;

  localparam int THR_W   = 14;
  localparam int SLOT_W  = 12;
  localparam int ID_W    = 5;
  localparam int LINE_W  = 2;
  localparam int RND_W   = 10;
  localparam int SYM_W   = 8;
  localparam int RETRY_W = 5;
  localparam int WAIT_W  = 22;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1000);
  localparam logic [SLOT_W-1:0] SLOT_RESET = SLOT_W'(64);
  localparam logic [ID_W-1:0]   ID_RESET   = '0;

  localparam logic [SYM_W-1:0] SYM_JAM  = 8'h78;
  localparam logic [SYM_W-1:0] SYM_BASE = 8'h41;

  localparam logic [LINE_W-1:0] LINE_IDLE = 2'd0;
  localparam logic [LINE_W-1:0] LINE_JAM  = 2'd2;

  localparam logic [RETRY_W-1:0] RETRY_MAX = '1;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_PERSIST_THR = 2'd0,
    REG_SLOT_TICKS  = 2'd1,
    REG_STATION_ID  = 2'd2
  } reg_idx_t;

  // what was driven last in the current frame
  typedef enum logic [1:0] {
    DRV_NONE = 2'd0,
    DRV_OWN  = 2'd1,
    DRV_JAM  = 2'd2
  } drv_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_before;
    logic              line_after_jam;
    logic [THR_W-1:0]  random_persist;
    logic [RND_W-1:0]  random_backoff;
  } in_item_t;

  typedef struct packed {
    logic               drive_valid;
    logic [SYM_W-1:0]   drive_symbol;
    logic               active;
    logic               collision_counted;
    logic [RETRY_W-1:0] retry_count;
  } out_item_t;

  typedef struct packed {
    logic [THR_W-1:0]  persist_threshold;
    logic [SLOT_W-1:0] slot_ticks;
    logic [ID_W-1:0]   station_id;
  } cfg_t;

  typedef struct packed {
    logic               idle_flag;
    logic [WAIT_W-1:0]  wait_count;
    logic [SLOT_W-1:0]  remaining;
    drv_t               last_drive;
    logic               jamming;
    logic [RETRY_W-1:0] retries;
  } state_t;

endpackage

[src/csma_regs.sv]
module csma_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csma_pkg::APB_AW-1:0]   paddr,
  input  logic [csma_pkg::APB_DW-1:0]   pwdata,
  output logic [csma_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output csma_pkg::cfg_t                cfg
);

  csma_pkg::cfg_t   cfg_r;
  csma_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = csma_pkg::reg_idx_t'(paddr[csma_pkg::APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.persist_threshold <= csma_pkg::THR_RESET;
      cfg_r.slot_ticks        <= csma_pkg::SLOT_RESET;
      cfg_r.station_id        <= csma_pkg::ID_RESET;
    end else if (wr_en) begin
      case (idx)
        csma_pkg::REG_PERSIST_THR: begin
          cfg_r.persist_threshold <= pwdata[csma_pkg::THR_W-1:0];
        end
        csma_pkg::REG_SLOT_TICKS: begin
          cfg_r.slot_ticks <= pwdata[csma_pkg::SLOT_W-1:0];
        end
        csma_pkg::REG_STATION_ID: begin
          cfg_r.station_id <= pwdata[csma_pkg::ID_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      csma_pkg::REG_PERSIST_THR: prdata = csma_pkg::APB_DW'(cfg_r.persist_threshold);
      csma_pkg::REG_SLOT_TICKS:  prdata = csma_pkg::APB_DW'(cfg_r.slot_ticks);
      csma_pkg::REG_STATION_ID:  prdata = csma_pkg::APB_DW'(cfg_r.station_id);
      default:                   prdata = '0;
    endcase
  end

endmodule

[src/csma_step.sv]
module csma_step (
  input  csma_pkg::state_t    st,
  input  csma_pkg::cfg_t      cfg,
  input  csma_pkg::in_item_t  item,
  output csma_pkg::state_t    st_nxt,
  output csma_pkg::out_item_t res
);

  localparam logic [csma_pkg::RETRY_W-1:0] LIMIT = csma_pkg::RETRY_W'(csma_pkg::RETRY_LIMIT);
  localparam logic [csma_pkg::RETRY_W-1:0] CAP   =
    csma_pkg::RETRY_W'(csma_pkg::BACKOFF_CAP_EXP);

  logic                              start;
  logic                              idle1;
  logic [csma_pkg::WAIT_W-1:0]       wait1;
  logic [csma_pkg::SLOT_W-1:0]       rem1;
  logic [csma_pkg::SLOT_W-1:0]       rem2;
  logic                              line_ok;
  logic                              drive;
  csma_pkg::drv_t                    last2;
  logic                              jam2;
  logic [csma_pkg::RETRY_W-1:0]      retries_inc;
  logic [csma_pkg::RETRY_W-1:0]      exp_e;
  logic [csma_pkg::RND_W-1:0]        slots;
  logic [csma_pkg::WAIT_W-1:0]       backoff;

  assign start   = st.idle_flag && (item.random_persist <= cfg.persist_threshold);
  assign idle1   = st.idle_flag && !start;
  assign wait1   = start ? '0 : st.wait_count;
  assign rem1    = (st.remaining == '0 && st.last_drive == csma_pkg::DRV_NONE) ?
                   cfg.slot_ticks : st.remaining;
  assign line_ok = (item.line_before == csma_pkg::LINE_IDLE) ||
                   (item.line_before == csma_pkg::LINE_JAM);
  assign drive   = (rem1 != '0) && line_ok;
  assign last2   = drive ? (st.jamming ? csma_pkg::DRV_JAM : csma_pkg::DRV_OWN) :
                   st.last_drive;
  assign rem2    = drive ? rem1 - 1'b1 : rem1;
  assign jam2    = st.jamming || (item.line_after_jam && last2 != csma_pkg::DRV_JAM);

  // exponent uses the already incremented retry count
  assign retries_inc = (st.retries == csma_pkg::RETRY_MAX) ? st.retries : st.retries + 1'b1;
  assign exp_e       = (retries_inc < CAP) ? retries_inc : CAP;

  always_comb begin
    for (int i = 0; i < csma_pkg::RND_W; i++) begin
      slots[i] = item.random_backoff[i] && (csma_pkg::RETRY_W'(i) < exp_e);
    end
  end

  assign backoff = csma_pkg::WAIT_W'(cfg.slot_ticks) * csma_pkg::WAIT_W'(slots)
                   + csma_pkg::WAIT_W'(1);

  always_comb begin
    st_nxt                = st;
    res.drive_valid       = 1'b0;
    res.drive_symbol      = '0;
    res.active            = 1'b1;
    res.collision_counted = 1'b0;

    if (st.retries > LIMIT) begin
      res.active = 1'b0;
    end else begin
      st_nxt.idle_flag  = idle1;
      st_nxt.wait_count = wait1;
      if (!idle1 && wait1 == '0) begin
        res.drive_valid = drive;
        if (drive) begin
          res.drive_symbol = st.jamming ? csma_pkg::SYM_JAM :
                             csma_pkg::SYM_BASE + csma_pkg::SYM_W'(cfg.station_id);
        end
        st_nxt.remaining  = rem2;
        st_nxt.last_drive = last2;
        st_nxt.jamming    = jam2;
        if (rem2 == '0) begin
          st_nxt.last_drive = csma_pkg::DRV_NONE;
          if (!jam2) begin
            st_nxt.idle_flag = 1'b1;
            st_nxt.retries   = '0;
          end else begin
            st_nxt.retries        = retries_inc;
            st_nxt.wait_count     = backoff;
            st_nxt.jamming        = 1'b0;
            res.collision_counted = 1'b1;
          end
        end
      end else if (!idle1 && (st.retries == '0 || item.line_before == csma_pkg::LINE_IDLE)) begin
        st_nxt.wait_count = wait1 - 1'b1;
      end
    end
    res.retry_count = st_nxt.retries;
  end

endmodule

[src/csma_cd_backoff_transmitter.sv]
// csma/cd station with p-persistent start and binary exponential backoff. each input
// transfer is one line tick and yields exactly one result transfer describing what the
// station drives on that tick. items move through an input register, one step of
// combinational station logic and a result register, so a new tick is taken every cycle
// while the result side is not stalled, and its result is registered as the tick fires.
// the station state register updates once per tick as the item leaves the input
// register, which sets the one-item-per-cycle rate. backoff after a collision is
// slot_ticks * (random bits masked to min(retries, 10)) + 1 ticks, counted down only on
// an idle line; beyond 16 retries the station stays silent until reset. the three
// configuration registers (threshold, slot length, station id) sit on a small apb port
// with pready tied high and should be written only while no tick is in flight.
module csma_cd_backoff_transmitter (
  input  logic                         clk,
  input  logic                         rst_n,
  // tick input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  csma_pkg::in_item_t           in_data,
  // result output
  output logic                         out_valid,
  input  logic                         out_ready,
  output csma_pkg::out_item_t          out_data,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [csma_pkg::APB_AW-1:0]  paddr,
  input  logic [csma_pkg::APB_DW-1:0]  pwdata,
  output logic [csma_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  csma_pkg::cfg_t      cfg;
  csma_pkg::state_t    st_r;
  csma_pkg::state_t    st_nxt;
  csma_pkg::in_item_t  in_r;
  logic                in_vld_r;
  csma_pkg::out_item_t res;
  csma_pkg::out_item_t out_r;
  logic                out_vld_r;
  logic                fire;
  logic                out_free;

  csma_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  csma_step u_step (
    .st     (st_r),
    .cfg    (cfg),
    .item   (in_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // result register can take a new result when empty or being drained
  assign out_free = !out_vld_r || out_ready;
  // the held tick is processed when there is room for its result
  assign fire     = in_vld_r && out_free;
  // input register refills when empty or emptying this cycle
  assign in_ready = !in_vld_r || fire;

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // station state advances once per processed tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.idle_flag  <= 1'b1;
      st_r.wait_count <= '0;
      st_r.remaining  <= '0;
      st_r.last_drive <= csma_pkg::DRV_NONE;
      st_r.jamming    <= 1'b0;
      st_r.retries    <= '0;
    end else if (fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  // a silent station never drives and never counts a collision
  a_silent_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.active) |-> (!out_r.drive_valid && !out_r.collision_counted))
    else $error("silent station produced line activity");

  // a counted collision always leaves a nonzero retry count
  a_coll_retry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.collision_counted) |-> (out_r.retry_count != '0))
    else $error("collision counted with zero retries");

  // no symbol when nothing is driven
  a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.drive_valid) |-> (out_r.drive_symbol == '0))
    else $error("symbol present without drive");

  // once past the retry limit the station state is frozen
  a_silent_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.retries > csma_pkg::RETRY_W'(csma_pkg::RETRY_LIMIT)) |=> $stable(st_r))
    else $error("silent station state changed");

endmodule

[tb/tb_csma_cd_backoff_transmitter.sv]
module tb_csma_cd_backoff_transmitter;
  import csma_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD = 60;

  // line codes that the package leaves unnamed
  localparam logic [LINE_W-1:0] LINE_OTHER = 2'd1;
  localparam logic [LINE_W-1:0] LINE_UNDEF = 2'd3;

  // station predictor plus the queue of drive results it still owes
  class drive_scoreboard;
    cfg_t        cfg;
    state_t      st;
    out_item_t   expected_drives[$];
    int unsigned mismatches;

    function new();
      cfg = '{persist_threshold: THR_RESET, slot_ticks: SLOT_RESET, station_id: ID_RESET};
      st = '0;
      st.idle_flag = 1'b1;
      mismatches = 0;
    endfunction

    function void set_register(reg_idx_t idx, logic [APB_DW-1:0] value);
      case (idx)
        REG_PERSIST_THR: cfg.persist_threshold = value[THR_W-1:0];
        REG_SLOT_TICKS:  cfg.slot_ticks = value[SLOT_W-1:0];
        REG_STATION_ID:  cfg.station_id = value[ID_W-1:0];
        default: ;
      endcase
    endfunction

    function bit silent();
      return st.retries > RETRY_LIMIT;
    endfunction

    // no frame pending, so a register write leaves no half-sent frame behind
    function bit quiet();
      return st.idle_flag || silent();
    endfunction

    function int unsigned pending();
      return expected_drives.size();
    endfunction

    // one line tick: advance the station and queue what it drives
    function void predict_tick(in_item_t tick);
      out_item_t   r;
      int unsigned exp_bits;
      int unsigned slots;
      r = '0;
      r.active = 1'b1;
      if (silent()) begin
        r.active = 1'b0;
      end else begin
        if (st.idle_flag && tick.random_persist <= cfg.persist_threshold) begin
          st.idle_flag = 1'b0;
          st.wait_count = '0;
        end
        if (!st.idle_flag && st.wait_count == 0) begin
          if (st.remaining == 0 && st.last_drive == DRV_NONE)
            st.remaining = cfg.slot_ticks;
          // only an idle or jammed line may be driven
          if (st.remaining != 0 &&
              (tick.line_before == LINE_IDLE || tick.line_before == LINE_JAM)) begin
            st.last_drive = st.jamming ? DRV_JAM : DRV_OWN;
            r.drive_valid = 1'b1;
            r.drive_symbol = st.jamming ? SYM_JAM : SYM_BASE + SYM_W'(cfg.station_id);
            st.remaining--;
          end
          if (tick.line_after_jam && st.last_drive != DRV_JAM)
            st.jamming = 1'b1;
          if (st.remaining == 0) begin
            st.last_drive = DRV_NONE;
            if (!st.jamming) begin
              st.idle_flag = 1'b1;
              st.retries = '0;
            end else begin
              if (st.retries != RETRY_MAX)
                st.retries++;
              // exponent capped, then slot_ticks per slot plus one tick
              exp_bits = (st.retries < BACKOFF_CAP_EXP) ? st.retries : BACKOFF_CAP_EXP;
              slots = tick.random_backoff & ((1 << exp_bits) - 1);
              st.wait_count = WAIT_W'(cfg.slot_ticks * slots + 1);
              st.jamming = 1'b0;
              r.collision_counted = 1'b1;
            end
          end
        end else if (!st.idle_flag && st.wait_count != 0 &&
                     (st.retries == 0 || tick.line_before == LINE_IDLE)) begin
          st.wait_count--;
        end
      end
      r.retry_count = st.retries;
      expected_drives.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", what, got, want);
      mismatches++;
    endtask

    task check_drive(out_item_t got);
      out_item_t want;
      if (expected_drives.size() == 0) begin
        report_mismatch("transfer with no tick pending", got, '0);
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_valid !== want.drive_valid)
        report_mismatch("drive_valid", got.drive_valid, want.drive_valid);
      if (got.drive_symbol !== want.drive_symbol)
        report_mismatch("drive_symbol", got.drive_symbol, want.drive_symbol);
      if (got.active !== want.active)
        report_mismatch("active", got.active, want.active);
      if (got.collision_counted !== want.collision_counted)
        report_mismatch("collision_counted", got.collision_counted, want.collision_counted);
      if (got.retry_count !== want.retry_count)
        report_mismatch("retry_count", got.retry_count, want.retry_count);
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  drive_scoreboard sb = new();

  csma_cd_backoff_transmitter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // result side: random stalls, plus a long hold-off when requested
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_drive(out_data);
  end

  function automatic in_item_t mk_tick(logic [LINE_W-1:0] line, logic after_jam,
                                       logic [THR_W-1:0] persist, logic [RND_W-1:0] backoff);
    in_item_t tick;
    tick.line_before = line;
    tick.line_after_jam = after_jam;
    tick.random_persist = persist;
    tick.random_backoff = backoff;
    return tick;
  endfunction

  // mostly idle line, rare jams, persist draws biased toward zero and the full range
  function automatic in_item_t random_tick();
    in_item_t    tick;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    tick.line_before = (pick < 70) ? LINE_IDLE : (pick < 82) ? LINE_JAM :
                       (pick < 95) ? LINE_OTHER : LINE_UNDEF;
    tick.line_after_jam = ($urandom_range(0, 9) == 0);
    pick = $urandom_range(0, 3);
    tick.random_persist = (pick == 0) ? '0 : (pick == 1) ? THR_W'($urandom) :
                          THR_W'($urandom_range(0, 9999));
    tick.random_backoff = RND_W'($urandom);
    return tick;
  endfunction

  // idle line, no jam, no new start unless the threshold is at its top
  function automatic in_item_t quiet_tick();
    return mk_tick(LINE_IDLE, 1'b0, '1, RND_W'($urandom));
  endfunction

  // every frame collides with the shortest backoff, so retries climb quickly to the limit
  function automatic in_item_t storm_tick();
    return mk_tick(LINE_IDLE, 1'b1, '0, '0);
  endfunction

  task automatic send_tick(input in_item_t tick);
    @(negedge clk);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.predict_tick(tick);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // finish any frame in flight, then wait for every result to come back
  task automatic close_phase();
    while (!sb.quiet()) send_tick(quiet_tick());
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold boundary, busy line on start, one full 64-tick frame
    send_tick(mk_tick(LINE_IDLE, 1'b0, 14'd1001, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b0, '1, '0));
    send_tick(mk_tick(LINE_UNDEF, 1'b0, 14'd1000, '0));
    close_phase();

    // highest station id, a collision jammed out, backoff gated by line state
    write_reg(REG_PERSIST_THR, 10000);
    write_reg(REG_SLOT_TICKS, 3);
    write_reg(REG_STATION_ID, 31);
    send_tick(mk_tick(LINE_OTHER, 1'b0, 14'd9999, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b1, '0, '0));
    send_tick(mk_tick(LINE_JAM, 1'b1, '0, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b0, '0, '1));
    send_tick(mk_tick(LINE_OTHER, 1'b0, '0, '0));
    send_tick(mk_tick(LINE_UNDEF, 1'b0, '0, '0));
    send_tick(mk_tick(LINE_JAM, 1'b0, '0, '0));
    repeat (7) send_tick(mk_tick(LINE_IDLE, 1'b0, '0, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b1, '1, '0));
    close_phase();

    // zero-length frames, with and without a collision
    write_reg(REG_SLOT_TICKS, 0);
    send_tick(mk_tick(LINE_IDLE, 1'b0, '0, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b1, '0, '1));
    send_tick(mk_tick(LINE_IDLE, 1'b0, '0, '0));
    send_tick(mk_tick(LINE_IDLE, 1'b0, '0, '0));
    close_phase();

    // random traffic under each idling pattern and a different setting each time
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_PERSIST_THR, 5000);
          write_reg(REG_SLOT_TICKS, 2);
          write_reg(REG_STATION_ID, 0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          write_reg(REG_PERSIST_THR, {THR_W{1'b1}});
          write_reg(REG_SLOT_TICKS, 1);
          write_reg(REG_STATION_ID, 7);
          send_idle_pct = 50;
          recv_stall_pct = 0;
        end
        2: begin
          write_reg(REG_PERSIST_THR, 0);
          write_reg(REG_SLOT_TICKS, 4);
          write_reg(REG_STATION_ID, 25);
          send_idle_pct = 0;
          recv_stall_pct = 50;
          // result side holds off while ticks keep coming, so the input backs up
          hold_left = LONG_HOLD;
        end
        default: begin
          write_reg(REG_PERSIST_THR, $urandom_range(0, 10000));
          write_reg(REG_SLOT_TICKS, $urandom_range(1, 8));
          write_reg(REG_STATION_ID, $urandom_range(0, 31));
          send_idle_pct = 30;
          recv_stall_pct = 30;
        end
      endcase
      repeat (100) send_tick(random_tick());
      close_phase();
    end

    // collide until the retry limit is passed, then the station must stay silent
    send_idle_pct = 30;
    recv_stall_pct = 30;
    write_reg(REG_SLOT_TICKS, 1);
    write_reg(REG_STATION_ID, 19);
    while (!sb.silent()) send_tick(storm_tick());
    repeat (6) send_tick(random_tick());
    close_phase();

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
